@@ src/htw_pkg.sv @@
// shared constants, codes and controller/datapath types for the timing wheel
package htw_pkg;
    localparam int WheelBits  = 6;
    localparam int WheelSize  = 1 << WheelBits;
    localparam int MaxTimers  = 32;
    localparam int IdxBits    = 5;
    localparam int TicksW     = 32;
    localparam int RoundsW    = TicksW - WheelBits;
    localparam int DivCntBits = 5;

    localparam logic [1:0] OpTick   = 2'd0;
    localparam logic [1:0] OpAdd    = 2'd1;
    localparam logic [1:0] OpCancel = 2'd2;
    localparam logic [1:0] OpIgnore = 2'd3;

    localparam logic [2:0] StFired    = 3'd0;
    localparam logic [2:0] StNoFire   = 3'd1;
    localparam logic [2:0] StAdded    = 3'd2;
    localparam logic [2:0] StFull     = 3'd3;
    localparam logic [2:0] StCanceled = 3'd4;
    localparam logic [2:0] StNotFound = 3'd5;

    typedef struct packed {
        logic load;
        logic div_step;
        logic scan_step;
        logic fin_step;
    } t_cmd;

    typedef struct packed {
        logic       div_done;
        logic       scan_done;
        logic       idx_last;
        logic       need_push;
        logic       out_free;
        logic [1:0] op;
    } t_sts;
endpackage

@@ src/htw_if.sv @@
// valid/ready channel interfaces for command and result beats
interface htw_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] timer_id;
    logic [31:0] interval;
    logic        periodic;
    modport source  (output valid, opcode, timer_id, interval, periodic, input ready);
    modport sink    (input valid, opcode, timer_id, interval, periodic, output ready);
    modport monitor (input valid, opcode, timer_id, interval, periodic, ready);
endinterface

interface htw_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] fired_id;
    logic        last;
    modport source  (output valid, status, fired_id, last, input ready);
    modport sink    (input valid, status, fired_id, last, output ready);
    modport monitor (input valid, status, fired_id, last, ready);
endinterface

@@ src/htw_ctrl.sv @@
// sequencer for accept, divide, entry scan and tick finish
module htw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_in_opcode,
    output logic          o_in_ready,
    input  htw_pkg::t_sts i_sts,
    output htw_pkg::t_cmd o_cmd
);
    localparam logic [1:0] SIdle = 2'd0;
    localparam logic [1:0] SDiv  = 2'd1;
    localparam logic [1:0] SScan = 2'd2;
    localparam logic [1:0] SFin  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       go;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        go         = !i_sts.need_push || i_sts.out_free;
        unique case (r_state)
            SIdle: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_opcode == htw_pkg::OpAdd) begin
                        n_state = SDiv;
                    end else if (i_in_opcode == htw_pkg::OpTick ||
                                 i_in_opcode == htw_pkg::OpCancel) begin
                        n_state = SScan;
                    end
                end
            end
            SDiv: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) n_state = SScan;
            end
            SScan: begin
                o_cmd.scan_step = go;
                if (go) begin
                    if (i_sts.op == htw_pkg::OpTick && i_sts.idx_last) begin
                        n_state = SFin;
                    end else if (i_sts.scan_done) begin
                        n_state = SIdle;
                    end
                end
            end
            SFin: begin
                o_cmd.fin_step = i_sts.out_free;
                if (i_sts.out_free) n_state = SIdle;
            end
            default: n_state = SIdle;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= SIdle;
        else          r_state <= n_state;
    end
endmodule

@@ src/htw_dp.sv @@
// entry table, interval divider, scan index and result register
module htw_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [15:0]   i_tick_length,
    htw_in_if.sink        i_in,
    htw_out_if.source     o_out,
    input  htw_pkg::t_cmd i_cmd,
    output htw_pkg::t_sts o_sts
);
    // entry table
    logic [htw_pkg::MaxTimers-1:0] r_valid;
    logic [15:0]                   r_eid     [htw_pkg::MaxTimers];
    logic [htw_pkg::WheelBits-1:0] r_eslot   [htw_pkg::MaxTimers];
    logic [htw_pkg::RoundsW-1:0]   r_erounds [htw_pkg::MaxTimers];
    logic                          r_erep    [htw_pkg::MaxTimers];
    logic [htw_pkg::TicksW-1:0]    r_eticks  [htw_pkg::MaxTimers];

    logic [htw_pkg::WheelBits-1:0] r_cur;
    logic [1:0]                    r_op;
    logic [15:0]                   r_id;
    logic                          r_per;
    logic [htw_pkg::IdxBits-1:0]   r_idx;
    logic [31:0]                   r_q;
    logic [15:0]                   r_rem;
    logic [15:0]                   r_div;
    logic [htw_pkg::DivCntBits-1:0] r_dcnt;
    logic                          r_pend;
    logic [15:0]                   r_pend_id;
    logic                          r_oval;
    logic [2:0]                    r_ost;
    logic [15:0]                   r_oid;
    logic                          r_olast;

    logic [16:0] trial;
    logic [17:0] diff;
    logic [31:0] ticks_new;
    logic        idx_last, match, fire, hit, out_free;
    logic        push_need, oval_set;
    logic [htw_pkg::TicksW-1:0]  e_ticks;
    logic [htw_pkg::RoundsW-1:0] e_hi;
    logic                        e_lo_zero;

    assign trial     = {r_rem, r_q[31]};
    assign diff      = {1'b0, trial} - {2'b00, r_div};
    assign ticks_new = (r_q == 32'd0) ? 32'd1 : r_q;
    assign idx_last  = r_idx == htw_pkg::IdxBits'(htw_pkg::MaxTimers - 1);
    assign match     = r_valid[r_idx] && r_eslot[r_idx] == r_cur;
    assign fire      = match && r_erounds[r_idx] == '0;
    assign hit       = (r_op == htw_pkg::OpAdd) ? !r_valid[r_idx]
                     : (r_valid[r_idx] && r_eid[r_idx] == r_id);
    assign out_free  = !r_oval || o_out.ready;
    assign e_ticks   = r_eticks[r_idx];
    assign e_hi      = e_ticks[htw_pkg::TicksW-1:htw_pkg::WheelBits];
    assign e_lo_zero = e_ticks[htw_pkg::WheelBits-1:0] == '0;
    assign push_need = (r_op == htw_pkg::OpTick) ? (fire && r_pend) : (hit || idx_last);
    assign oval_set  = (i_cmd.scan_step && push_need) || i_cmd.fin_step;

    // status toward the controller
    always_comb begin
        o_sts.op        = r_op;
        o_sts.idx_last  = idx_last;
        o_sts.out_free  = out_free;
        o_sts.div_done  = r_dcnt == '1;
        o_sts.scan_done = (r_op != htw_pkg::OpTick) && (hit || idx_last);
        o_sts.need_push = push_need;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_cur   <= '0;
            r_oval  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            if (oval_set) r_oval <= 1'b1;
            else if (o_out.ready) r_oval <= 1'b0;
            if (i_cmd.load) r_pend <= 1'b0;
            if (i_cmd.scan_step) begin
                if (r_op == htw_pkg::OpTick) begin
                    if (fire) begin
                        r_pend <= 1'b1;
                        if (!r_erep[r_idx]) r_valid[r_idx] <= 1'b0;
                    end
                end else begin
                    if (hit) r_valid[r_idx] <= (r_op == htw_pkg::OpAdd);
                end
            end
            if (i_cmd.fin_step) begin
                r_pend <= 1'b0;
                r_cur  <= r_cur + 1'b1;
            end
        end
    end

    // payload, divider and entry fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_in.opcode;
            r_id   <= i_in.timer_id;
            r_per  <= i_in.periodic;
            r_q    <= i_in.interval;
            r_rem  <= '0;
            r_div  <= (i_tick_length == 16'd0) ? 16'd1 : i_tick_length;
            r_dcnt <= '0;
            r_idx  <= '0;
        end
        // one quotient bit per step
        if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + 1'b1;
            if (!diff[17]) begin
                r_rem <= diff[15:0];
                r_q   <= {r_q[30:0], 1'b1};
            end else begin
                r_rem <= trial[15:0];
                r_q   <= {r_q[30:0], 1'b0};
            end
        end
        if (i_cmd.scan_step) begin
            r_idx <= r_idx + 1'b1;
            if (r_op == htw_pkg::OpTick) begin
                if (match && !fire) begin
                    r_erounds[r_idx] <= r_erounds[r_idx] - 1'b1;
                end
                if (fire) begin
                    if (r_pend) begin
                        r_ost   <= htw_pkg::StFired;
                        r_oid   <= r_pend_id;
                        r_olast <= 1'b0;
                    end
                    r_pend_id <= r_eid[r_idx];
                    // reschedule from the slot being visited
                    if (r_erep[r_idx]) begin
                        r_eslot[r_idx]   <= r_cur + e_ticks[htw_pkg::WheelBits-1:0];
                        r_erounds[r_idx] <= (e_lo_zero && e_hi != '0) ? e_hi - 1'b1 : e_hi;
                    end
                end
            end else begin
                if (hit || idx_last) begin
                    r_oid   <= '0;
                    r_olast <= 1'b1;
                    if (r_op == htw_pkg::OpAdd) r_ost <= hit ? htw_pkg::StAdded
                                                             : htw_pkg::StFull;
                    else r_ost <= hit ? htw_pkg::StCanceled : htw_pkg::StNotFound;
                end
                if (hit && r_op == htw_pkg::OpAdd) begin
                    r_eid[r_idx]     <= r_id;
                    r_erep[r_idx]    <= r_per;
                    r_eticks[r_idx]  <= ticks_new;
                    r_eslot[r_idx]   <= r_cur + ticks_new[htw_pkg::WheelBits-1:0];
                    r_erounds[r_idx] <= ticks_new[htw_pkg::TicksW-1:htw_pkg::WheelBits];
                end
            end
        end
        if (i_cmd.fin_step) begin
            r_ost   <= r_pend ? htw_pkg::StFired : htw_pkg::StNoFire;
            r_oid   <= r_pend ? r_pend_id : 16'd0;
            r_olast <= 1'b1;
        end
    end

    assign o_out.valid    = r_oval;
    assign o_out.status   = r_ost;
    assign o_out.fired_id = r_oid;
    assign o_out.last     = r_olast;
endmodule

@@ src/hashed_timing_wheel_core.sv @@
// top level of the hashed timing wheel: tick length register, sequencer, datapath
//  channel   dir  beat fields
//  i_in      in   opcode, timer_id, interval, periodic
//  o_out     out  status, fired_id, last
//  i_cfg_*   in   tick_length write (we, data)
// Add runs the 32-step divider, then the free-entry scan.
// Cancel runs the id scan; tick scans every entry, then takes a finish step.
// Each scan step that emits a beat waits while the result register is held.
// Reset clears the valid bits, the slot pointer and the handshake state at once.
module hashed_timing_wheel_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    htw_in_if.sink      i_in,
    htw_out_if.source   o_out
);
    htw_pkg::t_cmd cmd;
    htw_pkg::t_sts sts;
    logic [15:0]   r_tick_length;

    // tick length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_tick_length <= 16'd1;
        else if (i_cfg_we) r_tick_length <= i_cfg_data;
    end

    htw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_opcode (i_in.opcode),
        .o_in_ready  (i_in.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    htw_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick_length (r_tick_length),
        .i_in          (i_in),
        .o_out         (o_out),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

`ifndef SYNTH
    // an ignored opcode leaves the block ready
    a_ignored_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && i_in.opcode == htw_pkg::OpIgnore |=> i_in.ready)
        else $error("not ready after ignored opcode");
    // a tick without firing is always the final beat
    a_nofire_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status == htw_pkg::StNoFire |-> o_out.last)
        else $error("no-fire beat not last");
    // add and cancel answers are single final beats with no id
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status == htw_pkg::StAdded || o_out.status == htw_pkg::StFull ||
        o_out.status == htw_pkg::StCanceled || o_out.status == htw_pkg::StNotFound)
        |-> o_out.last && o_out.fired_id == 16'd0)
        else $error("bad add/cancel beat");
    // no new item is taken while the datapath is dividing or scanning
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.scan_step || cmd.div_step |-> !i_in.ready)
        else $error("ready while busy");
`endif
endmodule

@@ sim/htw_checker.sv @@
// checker for the timing wheel: watches both channels, predicts result beats, compares
module htw_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    htw_in_if.monitor   i_in,
    htw_out_if.monitor  i_out,
    output int          o_fail_count,
    output int          o_pending
);
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] fired_id;
        logic        last;
    } t_beat;

    t_beat exp_beats[$];

    // shadow timer table
    logic [15:0]                   tick_len;
    logic [htw_pkg::WheelBits-1:0] cur_slot;
    logic                          ent_valid [htw_pkg::MaxTimers];
    logic [15:0]                   ent_id    [htw_pkg::MaxTimers];
    logic [htw_pkg::WheelBits-1:0] ent_slot  [htw_pkg::MaxTimers];
    logic [htw_pkg::RoundsW-1:0]   ent_rounds[htw_pkg::MaxTimers];
    logic                          ent_rep   [htw_pkg::MaxTimers];
    logic [htw_pkg::TicksW-1:0]    ent_ticks [htw_pkg::MaxTimers];

    assign o_pending = exp_beats.size();

    // put a timer into its slot relative to the current slot
    function automatic void place_timer(int e, bit in_scan);
        logic [htw_pkg::WheelBits-1:0] s;
        logic [htw_pkg::RoundsW-1:0]   r;
        s = cur_slot + ent_ticks[e][htw_pkg::WheelBits-1:0];
        r = ent_ticks[e][htw_pkg::TicksW-1:htw_pkg::WheelBits];
        if (in_scan && s == cur_slot && r != 0) r = r - 1'b1;
        ent_slot[e]   = s;
        ent_rounds[e] = r;
    endfunction

    function automatic void push_beat(logic [2:0] st, logic [15:0] id, logic lst);
        t_beat b;
        b.status = st; b.fired_id = id; b.last = lst;
        exp_beats.insert(exp_beats.size(), b);
    endfunction

    // predict the beats of one command
    function automatic void predict_cmd(logic [1:0] op, logic [15:0] id,
                                        logic [31:0] ivl, logic per);
        int n;
        int e;
        logic [31:0] tl;
        logic [31:0] t;
        n = 0;
        e = 0;
        if (op == htw_pkg::OpTick) begin
            for (int k = 0; k < htw_pkg::MaxTimers; k++) begin
                if (!ent_valid[k] || ent_slot[k] != cur_slot) continue;
                if (ent_rounds[k] != 0) begin
                    ent_rounds[k] = ent_rounds[k] - 1'b1;
                    continue;
                end
                push_beat(htw_pkg::StFired, ent_id[k], 1'b0);
                n++;
                if (ent_rep[k]) place_timer(k, 1'b1);
                else ent_valid[k] = 1'b0;
            end
            if (n == 0) push_beat(htw_pkg::StNoFire, 16'd0, 1'b1);
            else exp_beats[$].last = 1'b1;
            cur_slot = cur_slot + 1'b1;
        end else if (op == htw_pkg::OpAdd) begin
            tl = (tick_len == 0) ? 32'd1 : {16'd0, tick_len};
            t = ivl / tl;
            if (t == 0) t = 1;
            while (e < htw_pkg::MaxTimers && ent_valid[e]) e++;
            if (e == htw_pkg::MaxTimers) push_beat(htw_pkg::StFull, 16'd0, 1'b1);
            else begin
                ent_valid[e] = 1'b1;
                ent_id[e]    = id;
                ent_rep[e]   = per;
                ent_ticks[e] = t;
                place_timer(e, 1'b0);
                push_beat(htw_pkg::StAdded, 16'd0, 1'b1);
            end
        end else if (op == htw_pkg::OpCancel) begin
            while (e < htw_pkg::MaxTimers && !(ent_valid[e] && ent_id[e] == id)) e++;
            if (e == htw_pkg::MaxTimers) push_beat(htw_pkg::StNotFound, 16'd0, 1'b1);
            else begin
                ent_valid[e] = 1'b0;
                push_beat(htw_pkg::StCanceled, 16'd0, 1'b1);
            end
        end
    endfunction

    // sample both channels at the clock edge
    always @(posedge i_clk) begin
        t_beat want;
        if (!i_rst_n) begin
            tick_len = 16'd1;
            cur_slot = '0;
            for (int k = 0; k < htw_pkg::MaxTimers; k++) ent_valid[k] = 1'b0;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) tick_len = i_cfg_data;
            if (i_out.valid && i_out.ready) begin
                if (exp_beats.size() == 0) begin
                    $error("unexpected beat status=%0d id=%0d", i_out.status, i_out.fired_id);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = exp_beats.pop_front();
                    if (want.status !== i_out.status) begin
                        $error("status: expected %0d actual %0d", want.status, i_out.status);
                        o_fail_count <= o_fail_count + 1;
                    end else if (want.fired_id !== i_out.fired_id) begin
                        $error("fired_id: expected %0d actual %0d", want.fired_id,
                               i_out.fired_id);
                        o_fail_count <= o_fail_count + 1;
                    end else if (want.last !== i_out.last) begin
                        $error("last: expected %0d actual %0d", want.last, i_out.last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                predict_cmd(i_in.opcode, i_in.timer_id, i_in.interval, i_in.periodic);
        end
    end
endmodule

@@ sim/tb_top.sv @@
// testbench top for the timing wheel: clock, reset, command stimulus and verdict
module tb_top;
    localparam int CycleLimit = 2000000;
    localparam int Drain      = 100;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;
    int          fail_count;
    int          pending;
    int          cycles;
    bit          quiet;

    htw_in_if  cmd_if ();
    htw_out_if res_if ();

    hashed_timing_wheel_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (cmd_if.sink),
        .o_out      (res_if.source)
    );

    htw_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in         (cmd_if.monitor),
        .i_out        (res_if.monitor),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side stalls in bursts
    initial begin
        res_if.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    // send one command beat, with an optional gap before it
    task automatic send_cmd(logic [1:0] op, logic [15:0] id, logic [31:0] ivl, logic per);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        cmd_if.valid    <= 1'b1;
        cmd_if.opcode   <= op;
        cmd_if.timer_id <= id;
        cmd_if.interval <= ivl;
        cmd_if.periodic <= per;
        do @(posedge i_clk); while (!cmd_if.ready);
    endtask

    task automatic idle_drain();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (Drain) @(posedge i_clk);
    endtask

    task automatic write_tick_len(logic [15:0] v);
        idle_drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // random command mix biased toward short intervals so timers fire
    task automatic random_cmds(int count, logic [15:0] tl);
        logic [1:0]  op;
        logic [31:0] ivl;
        int          r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            op = (r < 45) ? htw_pkg::OpTick : (r < 75) ? htw_pkg::OpAdd :
                 (r < 97) ? htw_pkg::OpCancel : htw_pkg::OpIgnore;
            case ($urandom_range(0, 5))
                0: ivl = $urandom;
                1: ivl = $urandom_range(0, 3);
                2: ivl = tl * $urandom_range(60, 200);
                default: ivl = tl * $urandom_range(0, 40);
            endcase
            send_cmd(op, ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15)),
                     ivl, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        cycles       = 0;
        quiet        = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = 16'd0;
        cmd_if.valid = 1'b0;
        cmd_if.opcode   = htw_pkg::OpTick;
        cmd_if.timer_id = 16'd0;
        cmd_if.interval = 32'd0;
        cmd_if.periodic = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every opcode, ignored opcode, duplicates, wheel multiple
        send_cmd(htw_pkg::OpTick, 16'd0, 32'd0, 1'b0);
        send_cmd(htw_pkg::OpAdd, 16'hFFFF, 32'd0, 1'b0);
        send_cmd(htw_pkg::OpAdd, 16'd7, 32'd64, 1'b1);
        send_cmd(htw_pkg::OpAdd, 16'd7, 32'd1, 1'b1);
        send_cmd(htw_pkg::OpAdd, 16'd9, 32'hFFFF_FFFF, 1'b1);
        send_cmd(htw_pkg::OpIgnore, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        send_cmd(htw_pkg::OpTick, 16'd0, 32'd0, 1'b0);
        send_cmd(htw_pkg::OpTick, 16'd0, 32'd0, 1'b0);
        send_cmd(htw_pkg::OpCancel, 16'd7, 32'd0, 1'b0);
        send_cmd(htw_pkg::OpCancel, 16'd1234, 32'd0, 1'b0);
        send_cmd(htw_pkg::OpCancel, 16'd9, 32'd0, 1'b0);
        for (int k = 0; k < 34; k++) send_cmd(htw_pkg::OpAdd, k[15:0], 32'd2, k[0]);
        send_cmd(htw_pkg::OpTick, 16'd0, 32'd0, 1'b0);
        send_cmd(htw_pkg::OpTick, 16'd0, 32'd0, 1'b0);

        // sender holds off until every result is back
        idle_drain();
        for (int k = 0; k < 34; k++) send_cmd(htw_pkg::OpCancel, k[15:0], 32'd0, 1'b0);

        write_tick_len(16'd0);
        random_cmds(70, 16'd1);
        write_tick_len(16'hFFFF);
        random_cmds(70, 16'hFFFF);
        write_tick_len(16'd3);
        random_cmds(100, 16'd3);
        write_tick_len(16'd1);
        random_cmds(100, 16'd1);
        quiet = 1'b1;
        random_cmds(60, 16'd1);
        idle_drain();

        if (fail_count == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule

@@ filelist.f @@
src/htw_pkg.sv
src/htw_if.sv
src/htw_ctrl.sv
src/htw_dp.sv
src/hashed_timing_wheel_core.sv
sim/htw_checker.sv
sim/tb_top.sv
